/* sv/spa_pkg.sv */
package spa_pkg;

    localparam int COORD_W   = 8;
    localparam int COLOR_W   = 8;
    localparam int LABEL_W   = 10;
    localparam int DIST_W    = 35;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int KIND_W    = 2;

    // squared 8-bit difference, sums of three and two squares, squared register
    localparam int SQ_W   = 2 * COLOR_W;
    localparam int DC2_W  = SQ_W + 2;
    localparam int DS2_W  = SQ_W + 1;
    localparam int CFG2_W = 2 * CFG_W;
    localparam int PC_W   = DC2_W + CFG2_W;
    localparam int PS_W   = DS2_W + CFG2_W;

    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CAND  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COMPACTNESS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SPACING = 1'd1;

    localparam logic [CFG_W-1:0] COMPACTNESS_RST  = 8'd10;
    localparam logic [CFG_W-1:0] GRID_SPACING_RST = 8'd16;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] pixel_l;
        logic [COLOR_W-1:0] pixel_a;
        logic [COLOR_W-1:0] pixel_b;
        logic [LABEL_W-1:0] center_index;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COLOR_W-1:0] center_l;
        logic [COLOR_W-1:0] center_a;
        logic [COLOR_W-1:0] center_b;
    } t_in_word;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic               label_valid;
        logic [DIST_W-1:0]  best_distance;
        logic               updated;
    } t_out_word;

    // OP_OOR: pixel outside the image, store untouched
    typedef enum logic [1:0] {
        OP_READ,
        OP_CLEAR,
        OP_CAND,
        OP_OOR
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [LABEL_W-1:0] label;
    } t_ctl;

    typedef struct packed {
        logic [DIST_W-1:0]  score;
        logic               lab_vld;
        logic [LABEL_W-1:0] lab;
    } t_entry;

    function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                    input logic [COLOR_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

/* sv/spa_if.sv */
interface spa_in_if;
    logic              valid;
    logic              ready;
    spa_pkg::t_in_word word;

    modport source(output valid, output word, input ready);
    modport sink(input valid, input word, output ready);
endinterface

interface spa_out_if;
    logic               valid;
    logic               ready;
    spa_pkg::t_out_word word;

    modport source(output valid, output word, input ready);
    modport sink(input valid, input word, output ready);
endinterface

/* sv/spa_calc.sv */
module spa_calc #(
    parameter int IMG_WIDTH    = 256,
    parameter int IMG_HEIGHT   = 256,
    parameter int MAX_CLUSTERS = 1024,
    parameter int ADDR_W       = $clog2(IMG_WIDTH * IMG_HEIGHT)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  spa_pkg::t_in_word           i_word,
    output logic                        o_rdy,
    input  logic [spa_pkg::CFG_W-1:0]   i_compactness,
    input  logic [spa_pkg::CFG_W-1:0]   i_grid_spacing,
    output logic                        o_vld,
    output spa_pkg::t_ctl               o_ctl,
    output logic [ADDR_W-1:0]           o_addr,
    output logic [spa_pkg::DIST_W-1:0]  o_q,
    input  logic                        i_rdy
);
    import spa_pkg::*;

    localparam int NST = 5;

    logic [NST:1]        r_v;
    logic [NST:1]        en;
    t_ctl                r_ctl  [1:NST];
    logic [ADDR_W-1:0]   r_addr [1:NST];

    logic [COLOR_W-1:0]  r1_d  [5];
    logic [SQ_W-1:0]     r2_sq [5];
    logic [DC2_W-1:0]    r3_dc2;
    logic [DS2_W-1:0]    r3_ds2;
    logic [PC_W-1:0]     r4_pc;
    logic [PS_W-1:0]     r4_ps;
    logic [DIST_W-1:0]   r5_q;
    logic [CFG2_W-1:0]   r_s2;
    logic [CFG2_W-1:0]   r_m2;

    t_ctl                n_ctl;
    logic [ADDR_W-1:0]   n_addr;
    logic                in_rng;

    // bubble-collapsing stall chain
    always_comb begin
        en[NST] = !r_v[NST] || i_rdy;
        for (int k = NST - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end
    assign o_rdy = en[1];

    always_comb begin
        in_rng = ({24'd0, i_word.pixel_x} < 32'(IMG_WIDTH)) &&
                 ({24'd0, i_word.pixel_y} < 32'(IMG_HEIGHT));
        n_ctl.label = i_word.center_index;
        n_addr      = '0;
        if (!in_rng) begin
            n_ctl.op = OP_OOR;
        end else begin
            n_addr = ADDR_W'(32'(i_word.pixel_y) * 32'(IMG_WIDTH) + 32'(i_word.pixel_x));
            unique case (i_word.kind)
                KIND_CLEAR: n_ctl.op = OP_CLEAR;
                KIND_CAND: begin
                    n_ctl.op = ({22'd0, i_word.center_index} < 32'(MAX_CLUSTERS))
                             ? OP_CAND : OP_READ;
                end
                KIND_READ: n_ctl.op = OP_READ;
                default:   n_ctl.op = OP_READ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) r_v[1] <= i_vld;
            for (int k = 2; k <= NST; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // squared weights; config must only change while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        r_s2 <= CFG2_W'(i_grid_spacing) * CFG2_W'(i_grid_spacing);
        r_m2 <= CFG2_W'(i_compactness) * CFG2_W'(i_compactness);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_ctl[1]  <= n_ctl;
            r_addr[1] <= n_addr;
            r1_d[0]   <= abs_diff(i_word.center_l, i_word.pixel_l);
            r1_d[1]   <= abs_diff(i_word.center_a, i_word.pixel_a);
            r1_d[2]   <= abs_diff(i_word.center_b, i_word.pixel_b);
            r1_d[3]   <= abs_diff(i_word.center_x, i_word.pixel_x);
            r1_d[4]   <= abs_diff(i_word.center_y, i_word.pixel_y);
        end
        for (int k = 2; k <= NST; k++) begin
            if (en[k]) begin
                r_ctl[k]  <= r_ctl[k-1];
                r_addr[k] <= r_addr[k-1];
            end
        end
        if (en[2]) begin
            for (int j = 0; j < 5; j++) begin
                r2_sq[j] <= SQ_W'(r1_d[j]) * SQ_W'(r1_d[j]);
            end
        end
        if (en[3]) begin
            r3_dc2 <= DC2_W'(r2_sq[0]) + DC2_W'(r2_sq[1]) + DC2_W'(r2_sq[2]);
            r3_ds2 <= DS2_W'(r2_sq[3]) + DS2_W'(r2_sq[4]);
        end
        if (en[4]) begin
            r4_pc <= PC_W'(r3_dc2) * PC_W'(r_s2);
            r4_ps <= PS_W'(r3_ds2) * PS_W'(r_m2);
        end
        if (en[5]) begin
            r5_q <= DIST_W'(r4_pc) + DIST_W'(r4_ps);
        end
    end

    assign o_vld  = r_v[NST];
    assign o_ctl  = r_ctl[NST];
    assign o_addr = r_addr[NST];
    assign o_q    = r5_q;

endmodule

/* sv/spa_store.sv */
module spa_store #(
    parameter int IMG_WIDTH  = 256,
    parameter int IMG_HEIGHT = 256,
    parameter int ADDR_W     = $clog2(IMG_WIDTH * IMG_HEIGHT)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  spa_pkg::t_ctl               i_ctl,
    input  logic [ADDR_W-1:0]           i_addr,
    input  logic [spa_pkg::DIST_W-1:0]  i_q,
    output logic                        o_rdy,
    output logic                        o_vld,
    output spa_pkg::t_out_word          o_word,
    input  logic                        i_rdy
);
    import spa_pkg::*;

    localparam int DEPTH = IMG_WIDTH * IMG_HEIGHT;

    t_entry              r_mem [DEPTH];
    t_entry              r_rdata;

    logic                r_v6;
    logic                r_v7;
    t_ctl                r6_ctl;
    logic [ADDR_W-1:0]   r6_addr;
    logic [DIST_W-1:0]   r6_q;
    t_out_word           r7_word;

    // last write, covers the write that lands in the same cycle as a read
    logic                r_lw_vld;
    logic [ADDR_W-1:0]   r_lw_addr;
    t_entry              r_lw_data;

    logic                en6;
    logic                en7;
    t_entry              cur;
    t_entry              n_entry;
    logic                we_op;
    logic                upd;
    logic                wr;

    assign en7   = !r_v7 || i_rdy;
    assign en6   = !r_v6 || en7;
    assign o_rdy = en6;

    always_comb begin
        cur     = (r_lw_vld && (r_lw_addr == r6_addr)) ? r_lw_data : r_rdata;
        n_entry = cur;
        we_op   = 1'b0;
        upd     = 1'b0;
        unique case (r6_ctl.op)
            OP_CLEAR: begin
                n_entry = '{score: '1, lab_vld: 1'b0, lab: '0};
                we_op   = 1'b1;
            end
            OP_CAND: begin
                if (r6_q <= cur.score) begin
                    n_entry = '{score: r6_q, lab_vld: 1'b1, lab: r6_ctl.label};
                    we_op   = 1'b1;
                    upd     = 1'b1;
                end
            end
            OP_READ: n_entry = cur;
            OP_OOR:  n_entry = '{score: '1, lab_vld: 1'b0, lab: '0};
            default: n_entry = cur;
        endcase
        wr = r_v6 && en7 && we_op;
    end

    always_ff @(posedge i_clk) begin
        if (en6 && i_vld) begin
            r_rdata <= r_mem[i_addr];
        end
        if (wr) begin
            r_mem[r6_addr] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6     <= 1'b0;
            r_v7     <= 1'b0;
            r_lw_vld <= 1'b0;
        end else begin
            if (en6) r_v6 <= i_vld;
            if (en7) r_v7 <= r_v6;
            if (wr)  r_lw_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r6_ctl  <= i_ctl;
            r6_addr <= i_addr;
            r6_q    <= i_q;
        end
        if (wr) begin
            r_lw_addr <= r6_addr;
            r_lw_data <= n_entry;
        end
        if (en7) begin
            r7_word.label         <= n_entry.lab;
            r7_word.label_valid   <= n_entry.lab_vld;
            r7_word.best_distance <= n_entry.score;
            r7_word.updated       <= upd;
        end
    end

    assign o_vld  = r_v7;
    assign o_word = r7_word;

endmodule

/* sv/slic_pixel_assignment_top.sv */
// A word accepted on i_in passes 7 register stages before it shows on o_out.
// Throughput: one word per cycle while o_out.ready holds, same-pixel words back to back included;
//   the store is read in the cycle before its read-modify-write stage and the last write is forwarded.
// Reset clears all valid bits and loads compactness 10, grid spacing 16.
// The pixel store is not cleared by reset; an entry is undefined until a clear word hits it.
module slic_pixel_assignment_top #(
    parameter int IMG_WIDTH    = 256,
    parameter int IMG_HEIGHT   = 256,
    parameter int MAX_CLUSTERS = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    spa_in_if.sink                         i_in,
    spa_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [spa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [spa_pkg::CFG_W-1:0]      i_cfg_data
);
    import spa_pkg::*;

    localparam int ADDR_W = $clog2(IMG_WIDTH * IMG_HEIGHT);

    logic [CFG_W-1:0]   r_compactness;
    logic [CFG_W-1:0]   r_grid_spacing;

    logic               c_vld;
    logic               c_rdy;
    t_ctl               c_ctl;
    logic [ADDR_W-1:0]  c_addr;
    logic [DIST_W-1:0]  c_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compactness  <= COMPACTNESS_RST;
            r_grid_spacing <= GRID_SPACING_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COMPACTNESS:  r_compactness  <= i_cfg_data;
                CFG_GRID_SPACING: r_grid_spacing <= i_cfg_data;
                default: ;
            endcase
        end
    end

    spa_calc #(
        .IMG_WIDTH    (IMG_WIDTH),
        .IMG_HEIGHT   (IMG_HEIGHT),
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .ADDR_W       (ADDR_W)
    ) u_calc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vld          (i_in.valid),
        .i_word         (i_in.word),
        .o_rdy          (i_in.ready),
        .i_compactness  (r_compactness),
        .i_grid_spacing (r_grid_spacing),
        .o_vld          (c_vld),
        .o_ctl          (c_ctl),
        .o_addr         (c_addr),
        .o_q            (c_q),
        .i_rdy          (c_rdy)
    );

    spa_store #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (c_vld),
        .i_ctl   (c_ctl),
        .i_addr  (c_addr),
        .i_q     (c_q),
        .o_rdy   (c_rdy),
        .o_vld   (o_out.valid),
        .o_word  (o_out.word),
        .i_rdy   (o_out.ready)
    );

endmodule
